@@ hw/rtl/rgb_to_yuv420_planar_packer_macros.svh @@
// Assertion macros shared by the RGB to YUV 4:2:0 packer modules.
// Depends on nothing; files that assert take it by include.
`ifndef RGB_TO_YUV420_PLANAR_PACKER_MACROS_SVH
`define RGB_TO_YUV420_PLANAR_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RY4P_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RY4P_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ry4p_pkg.sv @@
// Shared types and constants of the RGB to YUV 4:2:0 planar packer.
// Used by the front, queue, back and top-level files; depends on nothing.
`timescale 1ns / 1ps

package ry4p_pkg;

    localparam int DIM_W   = 11;  // width of a frame dimension
    localparam int OFF_W   = 21;  // width of a buffer offset
    localparam int SUM_W   = 18;  // signed color accumulator

    // Must stay a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [OFF_W-1:0] HEADER_BYTES = 21'd4;

    localparam logic signed [8:0] COEF_Y_R = 9'sd66;
    localparam logic signed [8:0] COEF_Y_G = 9'sd129;
    localparam logic signed [8:0] COEF_Y_B = 9'sd61;
    localparam logic signed [8:0] COEF_U_R = -9'sd46;
    localparam logic signed [8:0] COEF_U_G = -9'sd82;
    localparam logic signed [8:0] COEF_U_B = 9'sd128;
    localparam logic signed [8:0] COEF_V_R = 9'sd128;
    localparam logic signed [8:0] COEF_V_G = -9'sd94;
    localparam logic signed [8:0] COEF_V_B = -9'sd34;
    localparam logic signed [SUM_W-1:0] CHROMA_BIAS = 18'sd32768;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_LUMA   = 2'd1,
        KIND_U      = 2'd2,
        KIND_V      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_START,
        ST_WH,
        ST_WL,
        ST_HH,
        ST_HL,
        ST_Y,
        ST_U,
        ST_V
    } step_t;

    // One classified pixel, as handed from the front to the back.
    typedef struct packed {
        logic [7:0]       y_byte;
        logic [7:0]       u_byte;
        logic [7:0]       v_byte;
        logic [OFF_W-1:0] luma_off;
        logic [OFF_W-1:0] chroma_off;
        logic [OFF_W-1:0] plane_len;
        logic [DIM_W-1:0] hdr_w;
        logic [DIM_W-1:0] hdr_h;
        logic             first;
        logic             chroma;
        logic             frame_end;
    } entry_t;

    // Queue status and head toward the back end.
    typedef struct packed {
        logic   empty;
        entry_t head;
    } q_status_t;

endpackage

@@ hw/rtl/ry4p_front.sv @@
// Front end: accepts pixels, tracks raster position and offsets, converts
// the color and classifies the pixel. Depends on ry4p_pkg.
`timescale 1ns / 1ps

module ry4p_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,
    input  logic [ry4p_pkg::DIM_W-1:0] cfg_width,
    input  logic [ry4p_pkg::DIM_W-1:0] cfg_height,
    output logic                      push,
    input  logic                      queue_full,
    output ry4p_pkg::entry_t          push_entry
);

    localparam int DW      = ry4p_pkg::DIM_W;
    localparam int OW      = ry4p_pkg::OFF_W;
    localparam int SW      = ry4p_pkg::SUM_W;
    localparam int DIM_MAX = (1 << DW) - 1;
    localparam int EFF_W   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int EFF_H   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int COL_W   = $clog2(EFF_W);
    localparam int ROW_W   = $clog2(EFF_H);

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                                input int unsigned maxv);
        logic [DW-1:0] res;
        res = v;
        if (v == '0) begin
            res = DW'(1);
        end else if (32'(v) > maxv) begin
            res = DW'(maxv);
        end
        return res;
    endfunction

    // Position state
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [OW-1:0]    luma_reg, luma_next;
    logic [OW-1:0]    row_base_reg, row_base_next;
    logic [DW-1:0]    cur_w_reg, cur_h_reg;

    // Stage 1
    logic             s1_valid_reg;
    logic [23:0]      s1_pix_reg;
    logic [DW-1:0]    s1_w_reg, s1_h_reg;
    logic             s1_first_reg, s1_chroma_reg, s1_end_reg;
    logic [OW-1:0]    s1_luma_reg, s1_cpart_reg;

    // Stage 2
    logic             s2_valid_reg;
    logic [7:0]       s2_y_reg, s2_u_reg, s2_v_reg;
    logic [OW-1:0]    s2_ylen_reg, s2_plen_reg;
    logic [DW-1:0]    s2_w_reg, s2_h_reg;
    logic             s2_first_reg, s2_chroma_reg, s2_end_reg;
    logic [OW-1:0]    s2_luma_reg, s2_cpart_reg;

    logic             s1_ready, s2_ready, accept;
    logic             first, frame_end, col_wrap;
    logic [DW-1:0]    geo_w, geo_h, col_inc, row_inc;
    logic [DW:0]      w_up, s1_w_up, s1_h_up;
    logic [OW-1:0]    rb_step;

    logic [7:0]             pix_r, pix_g, pix_b;
    logic signed [SW-1:0]   y_sum, u_sum, v_sum;
    logic [2*DW-1:0]        ylen_full, plen_full;

    assign s2_ready = !s2_valid_reg || !queue_full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;
    assign accept   = s_tvalid && s1_ready;

    // Geometry is taken from the registers on the first pixel of a frame.
    assign first = (col_reg == '0) && (row_reg == '0);
    assign geo_w = first ? clamp_dim(cfg_width, MAX_WIDTH) : cur_w_reg;
    assign geo_h = first ? clamp_dim(cfg_height, MAX_HEIGHT) : cur_h_reg;

    assign col_inc   = DW'(col_reg) + 1'b1;
    assign row_inc   = DW'(row_reg) + 1'b1;
    assign col_wrap  = col_inc >= geo_w;
    assign frame_end = col_wrap && (row_inc >= geo_h);
    assign w_up      = {1'b0, geo_w} + 1'b1;
    assign rb_step   = OW'(w_up[DW:1]);

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        luma_next     = luma_reg;
        row_base_next = row_base_reg;
        if (accept) begin
            luma_next = luma_reg + 1'b1;
            if (col_wrap) begin
                col_next = '0;
                if (frame_end) begin
                    row_next      = '0;
                    luma_next     = ry4p_pkg::HEADER_BYTES;
                    row_base_next = '0;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                    // The chroma row advances after each odd luma row.
                    if (row_reg[0]) begin
                        row_base_next = row_base_reg + rb_step;
                    end
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            luma_reg     <= ry4p_pkg::HEADER_BYTES;
            row_base_reg <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            luma_reg     <= luma_next;
            row_base_reg <= row_base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && first) begin
            cur_w_reg <= geo_w;
            cur_h_reg <= geo_h;
        end
    end

    // Stage 1 load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg    <= s_tdata;
            s1_w_reg      <= geo_w;
            s1_h_reg      <= geo_h;
            s1_first_reg  <= first;
            s1_chroma_reg <= !col_reg[0] && !row_reg[0];
            s1_end_reg    <= frame_end;
            s1_luma_reg   <= luma_reg;
            s1_cpart_reg  <= row_base_reg + OW'(col_reg >> 1);
        end
    end

    // Color conversion and plane sizes
    assign pix_r = s1_pix_reg[7:0];
    assign pix_g = s1_pix_reg[15:8];
    assign pix_b = s1_pix_reg[23:16];

    always_comb begin
        y_sum = $signed({1'b0, pix_r}) * ry4p_pkg::COEF_Y_R
              + $signed({1'b0, pix_g}) * ry4p_pkg::COEF_Y_G
              + $signed({1'b0, pix_b}) * ry4p_pkg::COEF_Y_B;
        u_sum = $signed({1'b0, pix_r}) * ry4p_pkg::COEF_U_R
              + $signed({1'b0, pix_g}) * ry4p_pkg::COEF_U_G
              + $signed({1'b0, pix_b}) * ry4p_pkg::COEF_U_B
              + ry4p_pkg::CHROMA_BIAS;
        v_sum = $signed({1'b0, pix_r}) * ry4p_pkg::COEF_V_R
              + $signed({1'b0, pix_g}) * ry4p_pkg::COEF_V_G
              + $signed({1'b0, pix_b}) * ry4p_pkg::COEF_V_B
              + ry4p_pkg::CHROMA_BIAS;
    end

    assign s1_w_up   = {1'b0, s1_w_reg} + 1'b1;
    assign s1_h_up   = {1'b0, s1_h_reg} + 1'b1;
    assign ylen_full = s1_w_reg * s1_h_reg;
    assign plen_full = s1_w_up[DW:1] * s1_h_up[DW:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Bias keeps the chroma sums non-negative, so bits 15:8 give the byte.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_ready) begin
            s2_y_reg      <= y_sum[15:8];
            s2_u_reg      <= u_sum[15:8];
            s2_v_reg      <= v_sum[15:8];
            s2_ylen_reg   <= ylen_full[OW-1:0];
            s2_plen_reg   <= plen_full[OW-1:0];
            s2_w_reg      <= s1_w_reg;
            s2_h_reg      <= s1_h_reg;
            s2_first_reg  <= s1_first_reg;
            s2_chroma_reg <= s1_chroma_reg;
            s2_end_reg    <= s1_end_reg;
            s2_luma_reg   <= s1_luma_reg;
            s2_cpart_reg  <= s1_cpart_reg;
        end
    end

    assign push = s2_valid_reg && !queue_full;

    always_comb begin
        push_entry.y_byte     = s2_y_reg;
        push_entry.u_byte     = s2_u_reg;
        push_entry.v_byte     = s2_v_reg;
        push_entry.luma_off   = s2_luma_reg;
        push_entry.chroma_off = ry4p_pkg::HEADER_BYTES + s2_ylen_reg + s2_cpart_reg;
        push_entry.plane_len  = s2_plen_reg;
        push_entry.hdr_w      = s2_w_reg;
        push_entry.hdr_h      = s2_h_reg;
        push_entry.first      = s2_first_reg;
        push_entry.chroma     = s2_chroma_reg;
        push_entry.frame_end  = s2_end_reg;
    end

endmodule

@@ hw/rtl/ry4p_queue.sv @@
// Short queue of classified pixels between the front and the back end.
// Depends on ry4p_pkg and the packer assertion macros.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_planar_packer_macros.svh"

module ry4p_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ry4p_pkg::entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output ry4p_pkg::q_status_t status
);

    localparam int DEPTH = ry4p_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ry4p_pkg::entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full         = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;
    assign status.head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RY4P_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !full, "push into a full queue")
    `RY4P_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop, !status.empty, "pop from empty queue")
    `RY4P_ASSERT_NXT(a_push_count, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "count did not rise on push")
    `RY4P_ASSERT_NXT(a_pop_count, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1, "count did not fall on pop")

endmodule

@@ hw/rtl/ry4p_back.sv @@
// Back end: expands each queued pixel into header, luma and chroma beats
// and holds them in the output register. Depends on ry4p_pkg and the macros.
`timescale 1ns / 1ps
`include "rgb_to_yuv420_planar_packer_macros.svh"

module ry4p_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ry4p_pkg::q_status_t status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // byte_value[7:0], byte_offset[28:8]
    output logic                m_tlast,
    output logic [2:0]          m_tuser    // byte_kind[1:0], frame_done[2]
);

    localparam int OW = ry4p_pkg::OFF_W;

    ry4p_pkg::step_t  state_reg, state_next, eff_step, after_step;
    ry4p_pkg::entry_t head;
    logic             out_load, work;

    logic [7:0]       out_val;
    logic [OW-1:0]    out_off;
    ry4p_pkg::kind_t  out_kind;
    logic             out_last;

    logic             m_valid_reg;
    logic [7:0]       m_val_reg;
    logic [OW-1:0]    m_off_reg;
    ry4p_pkg::kind_t  m_kind_reg;
    logic             m_last_reg, m_done_reg;

    assign head     = status.head;
    assign out_load = !m_valid_reg || m_tready;
    assign work     = !status.empty && out_load;

    // A fresh entry starts with its header or directly with its luma byte.
    always_comb begin
        eff_step = state_reg;
        if (state_reg == ry4p_pkg::ST_START) begin
            eff_step = head.first ? ry4p_pkg::ST_WH : ry4p_pkg::ST_Y;
        end
    end

    // Next state
    always_comb begin
        case (eff_step)
            ry4p_pkg::ST_WH: after_step = ry4p_pkg::ST_WL;
            ry4p_pkg::ST_WL: after_step = ry4p_pkg::ST_HH;
            ry4p_pkg::ST_HH: after_step = ry4p_pkg::ST_HL;
            ry4p_pkg::ST_HL: after_step = ry4p_pkg::ST_Y;
            ry4p_pkg::ST_Y:  after_step = head.chroma ? ry4p_pkg::ST_U : ry4p_pkg::ST_START;
            ry4p_pkg::ST_U:  after_step = ry4p_pkg::ST_V;
            default:         after_step = ry4p_pkg::ST_START;
        endcase
        state_next = work ? after_step : state_reg;
    end

    assign pop = work && (after_step == ry4p_pkg::ST_START);

    // Outputs
    always_comb begin
        case (eff_step)
            ry4p_pkg::ST_WH: begin
                out_val  = {5'b0, head.hdr_w[10:8]};
                out_off  = OW'(0);
                out_kind = ry4p_pkg::KIND_HEADER;
                out_last = 1'b0;
            end
            ry4p_pkg::ST_WL: begin
                out_val  = head.hdr_w[7:0];
                out_off  = OW'(1);
                out_kind = ry4p_pkg::KIND_HEADER;
                out_last = 1'b0;
            end
            ry4p_pkg::ST_HH: begin
                out_val  = {5'b0, head.hdr_h[10:8]};
                out_off  = OW'(2);
                out_kind = ry4p_pkg::KIND_HEADER;
                out_last = 1'b0;
            end
            ry4p_pkg::ST_HL: begin
                out_val  = head.hdr_h[7:0];
                out_off  = OW'(3);
                out_kind = ry4p_pkg::KIND_HEADER;
                out_last = 1'b0;
            end
            ry4p_pkg::ST_Y: begin
                out_val  = head.y_byte;
                out_off  = head.luma_off;
                out_kind = ry4p_pkg::KIND_LUMA;
                out_last = !head.chroma;
            end
            ry4p_pkg::ST_U: begin
                out_val  = head.u_byte;
                out_off  = head.chroma_off;
                out_kind = ry4p_pkg::KIND_U;
                out_last = 1'b0;
            end
            ry4p_pkg::ST_V: begin
                out_val  = head.v_byte;
                out_off  = head.chroma_off + head.plane_len;
                out_kind = ry4p_pkg::KIND_V;
                out_last = 1'b1;
            end
            default: begin
                out_val  = '0;
                out_off  = '0;
                out_kind = ry4p_pkg::KIND_HEADER;
                out_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ry4p_pkg::ST_START;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= work;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            m_val_reg  <= out_val;
            m_off_reg  <= out_off;
            m_kind_reg <= out_kind;
            m_last_reg <= out_last;
            m_done_reg <= out_last && head.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, m_off_reg, m_val_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_done_reg, m_kind_reg};

    `RY4P_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_valid_reg && m_done_reg, m_last_reg, "frame end on a beat that does not close its pixel")
    `RY4P_ASSERT_NXT(a_u_then_v, aclk, aresetn, m_valid_reg && m_tready && (m_kind_reg == ry4p_pkg::KIND_U), m_valid_reg && (m_kind_reg == ry4p_pkg::KIND_V), "U beat not followed by its V beat")
    `RY4P_ASSERT_NXT(a_hdr_then_hdr_or_y, aclk, aresetn, m_valid_reg && m_tready && (m_kind_reg == ry4p_pkg::KIND_HEADER), m_valid_reg && ((m_kind_reg == ry4p_pkg::KIND_HEADER) || (m_kind_reg == ry4p_pkg::KIND_LUMA)), "header not followed by header or luma")

endmodule

@@ hw/rtl/rgb_to_yuv420_planar_packer.sv @@
// RGB to YUV 4:2:0 planar packer.
// Pixels enter on the s_ stream in raster order (red, green, blue in s_tdata
// from the low byte up). For each pixel the m_ stream carries one beat per
// byte to store: its value and buffer offset in m_tdata, its kind and the
// frame-done flag in m_tuser, and m_tlast on the pixel's final beat.
// The first pixel of a frame gives 4 header beats first; every pixel gives
// its luma beat, and pixels at even column and even row add U and V beats.
// So a pixel costs 1, 3 or 7 output beats, on average 1.5 over a frame,
// and the one-beat-per-cycle output sets the sustained pixel rate while
// m_tready stays high. The front takes one pixel per cycle while the
// four-entry queue has room. With the queue empty, a pixel's first beat
// is valid after the front stages, the queue and the output register.
// Frame width and height are written over APB at byte addresses 0 and 4 and
// are sampled at each frame's first pixel. Reset restores 640x480 and
// starts a new frame. When the receiver stalls, the output holds its beat,
// the queue and the two front stages fill and s_tready drops.
// Depends on ry4p_pkg, ry4p_front, ry4p_queue and ry4p_back.
`timescale 1ns / 1ps

module rgb_to_yuv420_planar_packer #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // byte_value[7:0], byte_offset[28:8]
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // byte_kind[1:0], frame_done[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = ry4p_pkg::DIM_W;

    logic [DW-1:0]        frame_width_reg, frame_height_reg;
    logic                 cfg_write;
    logic                 push, queue_full, pop;
    ry4p_pkg::entry_t     push_entry;
    ry4p_pkg::q_status_t  q_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DW'(640);
            frame_height_reg <= DW'(480);
        end else if (cfg_write) begin
            if (paddr[2]) begin
                frame_height_reg <= pwdata[DW-1:0];
            end else begin
                frame_width_reg <= pwdata[DW-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(frame_height_reg) : 32'(frame_width_reg);

    ry4p_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_width  (frame_width_reg),
        .cfg_height (frame_height_reg),
        .push       (push),
        .queue_full (queue_full),
        .push_entry (push_entry)
    );

    ry4p_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .status     (q_status)
    );

    ry4p_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
